@@ sv/srb_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srb_pkg: shared types and codes of the sequence reorder buffer
// Operation, result kind, push status and register index codes, plus the
// control group that the core drives into the window store.
// ----------------------------------------------------------------------------
package srb_pkg;

    // Field widths fixed by the interface
    localparam int SEQ_W       = 32;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;
    localparam int PEAK_W      = 6;

    // An emit releases at most this many numbers
    localparam int MAX_RESULTS = 32;
    localparam int RUN_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

    // Operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_EMIT = 1'b1;

    // Result kinds
    localparam logic [1:0] KIND_PUSH    = 2'd0;
    localparam logic [1:0] KIND_EMITTED = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    // Push status codes
    localparam logic [1:0] STATUS_STORED    = 2'd0;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
    localparam logic [1:0] STATUS_TOO_OLD   = 2'd2;
    localparam logic [1:0] STATUS_BEYOND    = 2'd3;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_START    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_WATCHDOG = 2'd1;

    // Window store control group
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_pending;
        logic clear_all;
    } window_ctl_t;

endpackage : srb_pkg
`default_nettype wire

@@ sv/sequence_reorder_buffer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_core: sequence-number reorder buffer
// Tracks out-of-order arrivals in a window bitmap and releases the in-order
// run at the head on request, with an optional sticky watchdog gate.
// ----------------------------------------------------------------------------
// One item is worked on at a time; s_ready is high while the core is idle,
// even when the previous result still waits in the output register. A push
// reads the bitmap RAM in the accept cycle; in the push state the slot is
// checked and written back once the output register is free. An emit walks
// the head run through the same RAM port, one slot per cycle, until a slot is
// not pending or the 32-number cap is reached, then sends one result beat per
// number released. An emit that releases nothing answers with one empty
// result; one refused by the gate does so without a scan. Results leave one
// per cycle unless m_ready stalls them. Reset needs no clearing pass: slot
// flags in flip-flops mark which RAM entries hold data.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_core
    import srb_pkg::*;
#(
    parameter int WINDOW = 32
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Input beats
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic                   s_op,
    input  wire logic [SEQ_W-1:0]       s_seq_in,
    input  wire logic                   s_watchdog_alive,
    // Result beats
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic      [1:0]             m_kind,
    output logic      [1:0]             m_push_status,
    output logic                        m_gated,
    output logic      [SEQ_W-1:0]       m_seq_out,
    output logic                        m_last,
    output logic      [SEQ_W-1:0]       m_received_count,
    output logic      [SEQ_W-1:0]       m_emitted_count,
    output logic      [PEAK_W-1:0]      m_peak_depth,
    // Configuration writes
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int SLOT_W = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int SUM_W  = ((SLOT_W > RUN_W) ? SLOT_W : RUN_W) + 1;
    localparam int CMP_W  = (CNT_W > PEAK_W) ? CNT_W : PEAK_W;

    localparam logic [SLOT_W-1:0] SLOT_LAST  = SLOT_W'(WINDOW - 1);
    localparam logic [SLOT_W:0]   SLOT_SPAN  = (SLOT_W + 1)'(WINDOW);
    localparam logic [SUM_W-1:0]  SUM_SPAN   = SUM_W'(WINDOW);
    localparam logic [SEQ_W-1:0]  SEQ_SPAN   = SEQ_W'(WINDOW);
    localparam logic [RUN_W-1:0]  RUN_CAP    = RUN_W'(MAX_RESULTS);

    // State codes
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PUSH = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;
    localparam logic [2:0] ST_NONE = 3'd4;

    // Control state
    logic [2:0]        state_reg,     state_next;
    logic [SEQ_W-1:0]  exp_seq_reg,   exp_seq_next;
    logic [SLOT_W-1:0] head_slot_reg, head_slot_next;
    logic [CNT_W-1:0]  pend_cnt_reg,  pend_cnt_next;
    logic              gate_open_reg, gate_open_next;
    logic              wd_en_reg,     wd_en_next;
    logic [SEQ_W-1:0]  recv_reg,      recv_next;
    logic [SEQ_W-1:0]  emit_tot_reg,  emit_tot_next;
    logic [PEAK_W-1:0] peak_reg,      peak_next;
    logic              out_valid_reg, out_valid_next;

    // Working registers
    logic [SLOT_W-1:0] push_slot_reg,   push_slot_next;
    logic              push_old_reg,    push_old_next;
    logic              push_beyond_reg, push_beyond_next;
    logic [SLOT_W-1:0] scan_addr_reg,   scan_addr_next;
    logic [RUN_W-1:0]  run_cnt_reg,     run_cnt_next;
    logic [RUN_W-1:0]  left_reg,        left_next;
    logic              gated_reg,       gated_next;

    // Output register payload
    logic [1:0]        out_kind_reg;
    logic [1:0]        out_status_reg;
    logic              out_gated_reg;
    logic [SEQ_W-1:0]  out_seq_reg;
    logic              out_last_reg;
    logic [SEQ_W-1:0]  out_recv_reg;
    logic [SEQ_W-1:0]  out_emit_reg;
    logic [PEAK_W-1:0] out_peak_reg;

    // Output load values
    logic              out_load;
    logic [1:0]        ld_kind;
    logic [1:0]        ld_status;
    logic              ld_gated;
    logic [SEQ_W-1:0]  ld_seq;
    logic              ld_last;
    logic [SEQ_W-1:0]  ld_recv;
    logic [SEQ_W-1:0]  ld_emit;
    logic [PEAK_W-1:0] ld_peak;

    // Window store interface
    window_ctl_t       win_ctl;
    logic [SLOT_W-1:0] win_rd_addr;
    logic [SLOT_W-1:0] win_wr_addr;
    logic              win_pending;

    // Datapath terms
    logic              out_free;
    logic [SEQ_W-1:0]  in_diff;
    logic              in_old;
    logic              in_beyond;
    logic [SLOT_W:0]   in_slot_sum;
    logic [SLOT_W-1:0] in_slot;
    logic [SLOT_W-1:0] scan_next_addr;
    logic [RUN_W-1:0]  run_cnt_inc;
    logic [RUN_W-1:0]  run_fin;
    logic              scan_stop;
    logic [SUM_W-1:0]  head_sum;
    logic [SLOT_W-1:0] head_adv;
    logic [SEQ_W:0]    emit_sum;
    logic [SEQ_W-1:0]  emit_sat;
    logic              push_stored;
    logic [CNT_W-1:0]  cnt_after;
    logic [CMP_W-1:0]  cnt_cmp;
    logic [PEAK_W-1:0] peak_push;
    logic [SEQ_W-1:0]  recv_sat;
    logic [1:0]        push_status;

    assign out_free = !out_valid_reg || m_ready;

    // Push classification and slot, relative to the head slot
    assign in_diff     = s_seq_in - exp_seq_reg;
    assign in_old      = s_seq_in < exp_seq_reg;
    assign in_beyond   = !in_old && (in_diff >= SEQ_SPAN);
    assign in_slot_sum = {1'b0, head_slot_reg} + {1'b0, in_diff[SLOT_W-1:0]};
    assign in_slot     = (in_slot_sum >= SLOT_SPAN) ? SLOT_W'(in_slot_sum - SLOT_SPAN)
                                                    : in_slot_sum[SLOT_W-1:0];

    // Head run walk
    assign scan_next_addr = (scan_addr_reg == SLOT_LAST) ? '0 : scan_addr_reg + 1'b1;
    assign run_cnt_inc    = run_cnt_reg + 1'b1;
    assign run_fin        = win_pending ? run_cnt_inc : run_cnt_reg;
    assign scan_stop      = !win_pending || (run_cnt_inc == RUN_CAP);
    assign head_sum       = SUM_W'(head_slot_reg) + SUM_W'(run_fin);
    assign head_adv       = (head_sum >= SUM_SPAN) ? SLOT_W'(head_sum - SUM_SPAN)
                                                   : head_sum[SLOT_W-1:0];
    assign emit_sum       = {1'b0, emit_tot_reg} + (SEQ_W + 1)'(run_fin);
    assign emit_sat       = emit_sum[SEQ_W] ? '1 : emit_sum[SEQ_W-1:0];

    // Push outcome
    assign push_stored = !push_old_reg && !push_beyond_reg && !win_pending;
    assign cnt_after   = push_stored ? pend_cnt_reg + 1'b1 : pend_cnt_reg;
    assign cnt_cmp     = CMP_W'(cnt_after);
    assign recv_sat    = (recv_reg == '1) ? recv_reg : recv_reg + 1'b1;

    always_comb begin
        priority if (push_old_reg) begin
            push_status = STATUS_TOO_OLD;
        end else if (push_beyond_reg) begin
            push_status = STATUS_BEYOND;
        end else if (win_pending) begin
            push_status = STATUS_DUPLICATE;
        end else begin
            push_status = STATUS_STORED;
        end
    end

    // Peak follows the pending count of in-window pushes, saturating
    always_comb begin
        peak_push = peak_reg;
        if (!push_old_reg && !push_beyond_reg && (cnt_cmp > CMP_W'(peak_reg))) begin
            peak_push = (cnt_cmp > CMP_W'(PEAK_MAX)) ? PEAK_MAX : PEAK_W'(cnt_cmp);
        end
    end

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        exp_seq_next     = exp_seq_reg;
        head_slot_next   = head_slot_reg;
        pend_cnt_next    = pend_cnt_reg;
        gate_open_next   = gate_open_reg;
        wd_en_next       = wd_en_reg;
        recv_next        = recv_reg;
        emit_tot_next    = emit_tot_reg;
        peak_next        = peak_reg;
        push_slot_next   = push_slot_reg;
        push_old_next    = push_old_reg;
        push_beyond_next = push_beyond_reg;
        scan_addr_next   = scan_addr_reg;
        run_cnt_next     = run_cnt_reg;
        left_next        = left_reg;
        gated_next       = gated_reg;

        win_ctl     = '0;
        win_rd_addr = head_slot_reg;
        win_wr_addr = scan_addr_reg;

        out_load  = 1'b0;
        ld_kind   = KIND_PUSH;
        ld_status = STATUS_STORED;
        ld_gated  = 1'b0;
        ld_seq    = '0;
        ld_last   = 1'b1;
        ld_recv   = recv_reg;
        ld_emit   = emit_tot_reg;
        ld_peak   = peak_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_op == OP_PUSH) begin
                        win_ctl.rd_en    = 1'b1;
                        win_rd_addr      = in_slot;
                        push_slot_next   = in_slot;
                        push_old_next    = in_old;
                        push_beyond_next = in_beyond;
                        state_next       = ST_PUSH;
                    end else if (wd_en_reg && !gate_open_reg && !s_watchdog_alive) begin
                        gated_next = 1'b1;
                        state_next = ST_NONE;
                    end else begin
                        // alive is high here whenever the gate still has to open
                        gate_open_next = gate_open_reg | wd_en_reg;
                        win_ctl.rd_en  = 1'b1;
                        win_rd_addr    = head_slot_reg;
                        scan_addr_next = head_slot_reg;
                        run_cnt_next   = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end

            ST_PUSH: begin
                // Read data is held by the RAM until the result can go out
                if (out_free) begin
                    win_ctl.wr_en      = push_stored;
                    win_ctl.wr_pending = 1'b1;
                    win_wr_addr        = push_slot_reg;
                    pend_cnt_next      = cnt_after;
                    recv_next          = recv_sat;
                    peak_next          = peak_push;
                    out_load           = 1'b1;
                    ld_kind            = KIND_PUSH;
                    ld_status          = push_status;
                    ld_recv            = recv_sat;
                    ld_peak            = peak_push;
                    state_next         = ST_IDLE;
                end
            end

            ST_SCAN: begin
                // Clear each pending head slot, read the next one ahead
                if (win_pending) begin
                    win_ctl.wr_en      = 1'b1;
                    win_ctl.wr_pending = 1'b0;
                    win_wr_addr        = scan_addr_reg;
                    run_cnt_next       = run_cnt_inc;
                end
                if (scan_stop) begin
                    head_slot_next = head_adv;
                    pend_cnt_next  = pend_cnt_reg - CNT_W'(run_fin);
                    emit_tot_next  = emit_sat;
                    left_next      = run_fin;
                    if (run_fin == '0) begin
                        gated_next = 1'b0;
                        state_next = ST_NONE;
                    end else begin
                        state_next = ST_EMIT;
                    end
                end else begin
                    win_ctl.rd_en  = 1'b1;
                    win_rd_addr    = scan_next_addr;
                    scan_addr_next = scan_next_addr;
                end
            end

            ST_EMIT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    ld_kind      = KIND_EMITTED;
                    ld_seq       = exp_seq_reg;
                    ld_last      = (left_reg == RUN_W'(1));
                    exp_seq_next = exp_seq_reg + 1'b1;
                    left_next    = left_reg - 1'b1;
                    if (left_reg == RUN_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            ST_NONE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    ld_kind    = KIND_NONE;
                    ld_gated   = gated_reg;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes: the user must write only while idle; the core does not enforce it
        if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_START: begin
                    exp_seq_next      = cfg_wr_data[SEQ_W-1:0];
                    head_slot_next    = '0;
                    pend_cnt_next     = '0;
                    win_ctl.clear_all = 1'b1;
                end
                CFG_WATCHDOG: begin
                    wd_en_next     = cfg_wr_data[0];
                    gate_open_next = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Output register handshake
    always_comb begin
        if (out_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            exp_seq_reg   <= '0;
            head_slot_reg <= '0;
            pend_cnt_reg  <= '0;
            gate_open_reg <= 1'b0;
            wd_en_reg     <= 1'b0;
            recv_reg      <= '0;
            emit_tot_reg  <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            exp_seq_reg   <= exp_seq_next;
            head_slot_reg <= head_slot_next;
            pend_cnt_reg  <= pend_cnt_next;
            gate_open_reg <= gate_open_next;
            wd_en_reg     <= wd_en_next;
            recv_reg      <= recv_next;
            emit_tot_reg  <= emit_tot_next;
            peak_reg      <= peak_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        push_slot_reg   <= push_slot_next;
        push_old_reg    <= push_old_next;
        push_beyond_reg <= push_beyond_next;
        scan_addr_reg   <= scan_addr_next;
        run_cnt_reg     <= run_cnt_next;
        left_reg        <= left_next;
        gated_reg       <= gated_next;
        if (out_load) begin
            out_kind_reg   <= ld_kind;
            out_status_reg <= ld_status;
            out_gated_reg  <= ld_gated;
            out_seq_reg    <= ld_seq;
            out_last_reg   <= ld_last;
            out_recv_reg   <= ld_recv;
            out_emit_reg   <= ld_emit;
            out_peak_reg   <= ld_peak;
        end
    end

    srb_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (win_ctl),
        .rd_addr (win_rd_addr),
        .wr_addr (win_wr_addr),
        .pending (win_pending)
    );

    assign s_ready          = (state_reg == ST_IDLE);
    assign m_valid          = out_valid_reg;
    assign m_kind           = out_kind_reg;
    assign m_push_status    = out_status_reg;
    assign m_gated          = out_gated_reg;
    assign m_seq_out        = out_seq_reg;
    assign m_last           = out_last_reg;
    assign m_received_count = out_recv_reg;
    assign m_emitted_count  = out_emit_reg;
    assign m_peak_depth     = out_peak_reg;

endmodule : sequence_reorder_buffer_core
`default_nettype wire

@@ sv/srb_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srb_ram: generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered.
// Read data holds while the read enable is low.
// ----------------------------------------------------------------------------
module srb_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 32,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : srb_ram
`default_nettype wire

@@ sv/srb_window.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srb_window: pending bitmap of the reorder window
// Pending flags live in a one-bit RAM; a written flag per slot (cleared at
// reset and on a start write) masks slots not touched since the last clear.
// ----------------------------------------------------------------------------
module srb_window
    import srb_pkg::*;
#(
    parameter int WINDOW = 32,
    localparam int SLOT_W = $clog2(WINDOW)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire window_ctl_t       ctl,
    input  wire logic [SLOT_W-1:0] rd_addr,
    input  wire logic [SLOT_W-1:0] wr_addr,
    output logic                   pending
);

    logic [WINDOW-1:0] written_reg;
    logic [WINDOW-1:0] written_next;
    logic              written_q_reg;
    logic              ram_rdata;

    // Written flags: cleared in one go, set on any write to the slot
    always_comb begin
        written_next = written_reg;
        if (ctl.clear_all) begin
            written_next = '0;
        end else if (ctl.wr_en) begin
            written_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg <= '0;
        end else begin
            written_reg <= written_next;
        end
    end

    // Flag sampled alongside the RAM read so both line up
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            written_q_reg <= written_reg[rd_addr];
        end
    end

    srb_ram #(
        .WIDTH (1),
        .DEPTH (WINDOW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ctl.wr_en),
        .waddr (wr_addr),
        .wdata (ctl.wr_pending),
        .re    (ctl.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign pending = written_q_reg & ram_rdata;

endmodule : srb_window
`default_nettype wire

@@ sv/srb_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// srb_checker: port-level checks of the sequence reorder buffer
// Watches the result channel for stall stability and field consistency.
// ----------------------------------------------------------------------------
module srb_checker
    import srb_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   s_valid,
    input wire logic                   s_ready,
    input wire logic                   s_op,
    input wire logic [SEQ_W-1:0]       s_seq_in,
    input wire logic                   s_watchdog_alive,
    input wire logic                   m_valid,
    input wire logic                   m_ready,
    input wire logic [1:0]             m_kind,
    input wire logic [1:0]             m_push_status,
    input wire logic                   m_gated,
    input wire logic [SEQ_W-1:0]       m_seq_out,
    input wire logic                   m_last,
    input wire logic [SEQ_W-1:0]       m_received_count,
    input wire logic [SEQ_W-1:0]       m_emitted_count,
    input wire logic [PEAK_W-1:0]      m_peak_depth,
    input wire logic                   cfg_wr_en,
    input wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input wire logic [CFG_DATA_W-1:0]  cfg_wr_data
);

    // A stalled result beat holds its kind, number, last flag and emitted count
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind) && $stable(m_seq_out)
            && $stable(m_last) && $stable(m_emitted_count))
        else $error("result beat changed while stalled");

    // A push answer is a single closing beat with no number
    a_push_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_PUSH |-> m_last && !m_gated && m_seq_out == '0)
        else $error("malformed push answer");

    // Only push answers carry a status
    a_status_push_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_PUSH |-> m_push_status == STATUS_STORED)
        else $error("status on a non-push result");

    // Empty emits close at once and carry no number
    a_none_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_NONE |-> m_last && m_seq_out == '0)
        else $error("malformed empty emit result");

    // Refusal only comes as an empty emit result
    a_gated_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_gated |-> m_kind == KIND_NONE)
        else $error("gated flag on a result that is not an empty emit");

endmodule : srb_checker

bind sequence_reorder_buffer_core srb_checker u_srb_checker (.*);
`default_nettype wire

@@ tb/sv/tb_sequence_reorder_buffer_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sequence_reorder_buffer_core: self-checking bench for the reorder buffer
// A directed table covers window edges, duplicates, stale and far numbers,
// the watchdog gate and wrap at the top of the number space. Random bursts of
// shuffled numbers with late arrivals and stray pushes follow. Every result
// beat is checked field by field against a window model, or a typed table answer.
// ----------------------------------------------------------------------------
module tb_sequence_reorder_buffer_core;
    import srb_pkg::*;

    localparam int WIN          = 32;
    localparam int IDLE_MAX     = 4;
    localparam int HOLD_CYCLES  = 80;
    localparam int HOLD_PHASE   = 3;
    localparam int RANDOM_ITEMS = 500;
    localparam int TAIL_CYCLES  = 40;
    localparam int STALL_LIMIT  = 1000;
    localparam int MAX_REPORTS  = 40;

    // Indexes with no register behind them
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNMAPPED_B = 2'd3;

    typedef enum logic { ROW_BEAT, ROW_WRITE } row_kind_e;

    typedef struct packed {
        row_kind_e              what;
        logic                   op;
        logic [CFG_INDEX_W-1:0] index;
        logic [SEQ_W-1:0]       value;
        logic                   alive;
        logic                   typed;
        logic [1:0]             kind;
        logic [1:0]             status;
        logic                   gated;
    } directed_row_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        status;
        logic              gated;
        logic [SEQ_W-1:0]  seq;
        logic              last;
        logic [SEQ_W-1:0]  received;
        logic [SEQ_W-1:0]  emitted;
        logic [PEAK_W-1:0] peak;
    } reorder_beat_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_op;
    logic [SEQ_W-1:0]       s_seq_in;
    logic                   s_watchdog_alive;
    logic                   m_valid;
    logic                   m_ready;
    logic [1:0]             m_kind;
    logic [1:0]             m_push_status;
    logic                   m_gated;
    logic [SEQ_W-1:0]       m_seq_out;
    logic                   m_last;
    logic [SEQ_W-1:0]       m_received_count;
    logic [SEQ_W-1:0]       m_emitted_count;
    logic [PEAK_W-1:0]      m_peak_depth;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_wr_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    // Hand-written answers travel with the beat they belong to
    logic                   row_typed;
    logic [1:0]             row_kind;
    logic [1:0]             row_status;
    logic                   row_gated;

    // Model of the window
    logic [WIN-1:0]         held_bits;
    logic [SEQ_W-1:0]       head_seq;
    int                     held_count;
    int                     held_peak;
    logic                   watchdog_on;
    logic                   gate_opened;
    logic [SEQ_W-1:0]       pushes_seen;
    logic [SEQ_W-1:0]       numbers_released;

    reorder_beat_t          expected_beats[$];
    int                     error_count     = 0;
    int                     beats_sent      = 0;
    int                     source_idle_max = IDLE_MAX;
    int                     sink_idle_max   = IDLE_MAX;
    int                     hold_requests   = 0;
    int                     hold_served     = 0;
    logic [SEQ_W-1:0]       burst_base;

    directed_row_t directed_rows [32] = '{
        // what    op       reg             value          alive typed kind  status  gated
        '{ROW_BEAT,  OP_EMIT, CFG_START, 32'h0000_0000, 1'b0, 1'b1, KIND_NONE,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h0000_0000, 1'b0, 1'b1, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h0000_0000, 1'b1, 1'b1, KIND_PUSH,
          STATUS_DUPLICATE, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h0000_001F, 1'b0, 1'b1, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h0000_0020, 1'b1, 1'b1, KIND_PUSH,
          STATUS_BEYOND, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'hFFFF_FFFF, 1'b0, 1'b1, KIND_PUSH,
          STATUS_BEYOND, 1'b0},
        '{ROW_BEAT,  OP_EMIT, CFG_START, 32'h0000_0000, 1'b1, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h0000_0000, 1'b0, 1'b1, KIND_PUSH,
          STATUS_TOO_OLD, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h0000_0001, 1'b0, 1'b1, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_EMIT, CFG_START, 32'hFFFF_FFFF, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_WRITE, OP_PUSH, CFG_WATCHDOG, 32'h0000_0001, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_EMIT, CFG_START, 32'h0000_0000, 1'b0, 1'b1, KIND_NONE,
          STATUS_STORED, 1'b1},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h0000_0002, 1'b0, 1'b1, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_EMIT, CFG_START, 32'h0000_0000, 1'b1, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_EMIT, CFG_START, 32'h0000_0000, 1'b0, 1'b1, KIND_NONE,
          STATUS_STORED, 1'b0},
        '{ROW_WRITE, OP_PUSH, CFG_START, 32'hFFFF_FFF0, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'hFFFF_FFEF, 1'b0, 1'b1, KIND_PUSH,
          STATUS_TOO_OLD, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'hFFFF_FFF0, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_EMIT, CFG_START, 32'h0000_0000, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_WRITE, OP_PUSH, CFG_WATCHDOG, 32'hFFFF_FFFE, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_WRITE, OP_PUSH, CFG_START, 32'hFFFF_FFFF, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'hFFFF_FFFF, 1'b0, 1'b1, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_EMIT, CFG_START, 32'h0000_0000, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h0000_0000, 1'b0, 1'b1, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h8000_0000, 1'b0, 1'b1, KIND_PUSH,
          STATUS_BEYOND, 1'b0},
        '{ROW_WRITE, OP_PUSH, CFG_UNMAPPED_A, 32'hFFFF_FFFF, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_WRITE, OP_PUSH, CFG_UNMAPPED_B, 32'h0000_0000, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_EMIT, CFG_START, 32'h0000_0000, 1'b1, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h0000_0020, 1'b0, 1'b1, KIND_PUSH,
          STATUS_STORED, 1'b0},
        '{ROW_BEAT,  OP_PUSH, CFG_START, 32'h0000_0021, 1'b0, 1'b1, KIND_PUSH,
          STATUS_BEYOND, 1'b0},
        '{ROW_WRITE, OP_PUSH, CFG_START, 32'h0000_0000, 1'b0, 1'b0, KIND_PUSH,
          STATUS_STORED, 1'b0}
    };

    sequence_reorder_buffer_core #(
        .WINDOW(WIN)
    ) DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_seq_in         (s_seq_in),
        .s_watchdog_alive (s_watchdog_alive),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_kind           (m_kind),
        .m_push_status    (m_push_status),
        .m_gated          (m_gated),
        .m_seq_out        (m_seq_out),
        .m_last           (m_last),
        .m_received_count (m_received_count),
        .m_emitted_count  (m_emitted_count),
        .m_peak_depth     (m_peak_depth),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [SEQ_W-1:0] want,
                                   input logic [SEQ_W-1:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // Works out the beats that one input causes and queues them
    task automatic predict_release(input logic op, input logic [SEQ_W-1:0] seq,
                                   input logic alive);
        reorder_beat_t beats[$];
        reorder_beat_t b;
        logic [SEQ_W:0] window_end;
        int slot;
        beats = {};
        if (op == OP_PUSH) begin
            b = '0;
            b.kind = KIND_PUSH;
            b.last = 1'b1;
            if (pushes_seen != '1) pushes_seen++;
            window_end = {1'b0, head_seq} + (SEQ_W + 1)'(WIN);
            slot = int'(seq % WIN);
            if (seq < head_seq) begin
                b.status = STATUS_TOO_OLD;
            end else if ({1'b0, seq} >= window_end) begin
                b.status = STATUS_BEYOND;
            end else begin
                if (held_bits[slot]) begin
                    b.status = STATUS_DUPLICATE;
                end else begin
                    held_bits[slot] = 1'b1;
                    held_count++;
                    b.status = STATUS_STORED;
                end
                if (held_count > held_peak) held_peak = (held_count > 63) ? 63 : held_count;
            end
            beats.push_back(b);
        end else if (watchdog_on && !gate_opened && !alive) begin
            // gate still shut: refused
            b = '0;
            b.kind = KIND_NONE;
            b.gated = 1'b1;
            b.last = 1'b1;
            beats.push_back(b);
        end else begin
            if (watchdog_on) gate_opened = 1'b1;
            // release the head run, capped per emit
            while (beats.size() < MAX_RESULTS && held_bits[int'(head_seq % WIN)]) begin
                held_bits[int'(head_seq % WIN)] = 1'b0;
                if (held_count > 0) held_count--;
                b = '0;
                b.kind = KIND_EMITTED;
                b.seq = head_seq;
                beats.push_back(b);
                head_seq++;
                if (numbers_released != '1) numbers_released++;
            end
            if (beats.size() == 0) begin
                b = '0;
                b.kind = KIND_NONE;
                b.last = 1'b1;
                beats.push_back(b);
            end else begin
                b = beats[beats.size() - 1];
                b.last = 1'b1;
                beats[beats.size() - 1] = b;
            end
        end
        // statistics are those after the whole input
        foreach (beats[i]) begin
            b = beats[i];
            b.received = pushes_seen;
            b.emitted = numbers_released;
            b.peak = PEAK_W'(held_peak);
            expected_beats.push_back(b);
        end
    endtask

    // Model update and result checking, all at the rising edge
    always @(posedge aclk) begin : scoreboard
        int first_new;
        reorder_beat_t got;
        reorder_beat_t want;
        if (!aresetn) begin
            held_bits = '0;
            head_seq = '0;
            held_count = 0;
            held_peak = 0;
            watchdog_on = 1'b0;
            gate_opened = 1'b0;
            pushes_seen = '0;
            numbers_released = '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_START: begin
                        head_seq = cfg_wr_data;
                        held_bits = '0;
                        held_count = 0;
                    end
                    CFG_WATCHDOG: begin
                        watchdog_on = cfg_wr_data[0];
                        gate_opened = 1'b0;
                    end
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got.kind = m_kind;
                got.status = m_push_status;
                got.gated = m_gated;
                got.seq = m_seq_out;
                got.last = m_last;
                got.received = m_received_count;
                got.emitted = m_emitted_count;
                got.peak = m_peak_depth;
                if (expected_beats.size() == 0) begin
                    report_mismatch("unexpected beat, seq_out", '0, got.seq);
                end else begin
                    want = expected_beats.pop_front();
                    if (got.kind !== want.kind) report_mismatch("kind", want.kind, got.kind);
                    if (got.status !== want.status)
                        report_mismatch("push_status", want.status, got.status);
                    if (got.gated !== want.gated) report_mismatch("gated", want.gated, got.gated);
                    if (got.seq !== want.seq) report_mismatch("seq_out", want.seq, got.seq);
                    if (got.last !== want.last) report_mismatch("last", want.last, got.last);
                    if (got.received !== want.received)
                        report_mismatch("received_count", want.received, got.received);
                    if (got.emitted !== want.emitted)
                        report_mismatch("emitted_count", want.emitted, got.emitted);
                    if (got.peak !== want.peak) report_mismatch("peak_depth", want.peak, got.peak);
                end
            end
            if (s_valid && s_ready) begin
                first_new = expected_beats.size();
                predict_release(s_op, s_seq_in, s_watchdog_alive);
                // hand-written kind, status and gated flag replace the model's in its first beat
                if (row_typed) begin
                    want = expected_beats[first_new];
                    want.kind = row_kind;
                    want.status = row_status;
                    want.gated = row_gated;
                    expected_beats[first_new] = want;
                end
            end
        end
    end

    // Result side: random ready gaps, plus one long hold on request
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        forever begin
            gap = $urandom_range(0, sink_idle_max);
            if (hold_served != hold_requests) begin
                hold_served++;
                gap = HOLD_CYCLES;
            end
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && aresetn));
        end
    end

    // Ends the run when nothing moves for too long
    initial begin : stall_watch
        int stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en || !aresetn)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("tb_sequence_reorder_buffer_core: done, errors");
        $finish;
    end

    // One input beat; valid stays up across back-to-back beats
    task automatic send_beat(input logic op, input logic [SEQ_W-1:0] seq, input logic alive,
                             input logic typed, input logic [1:0] kind,
                             input logic [1:0] status, input logic gated);
        int gap;
        gap = $urandom_range(0, source_idle_max);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_seq_in <= seq;
        s_watchdog_alive <= alive;
        row_typed <= typed;
        row_kind <= kind;
        row_status <= status;
        row_gated <= gated;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
    endtask

    task automatic push_number(input logic [SEQ_W-1:0] seq);
        send_beat(OP_PUSH, seq, 1'($urandom_range(0, 1)), 1'b0, KIND_PUSH, STATUS_STORED, 1'b0);
    endtask

    task automatic request_release();
        send_beat(OP_EMIT, $urandom(), ($urandom_range(0, 3) != 0), 1'b0, KIND_PUSH,
                  STATUS_STORED, 1'b0);
    endtask

    // Stop offering and let every queued result come out
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(negedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_drained();
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // A shuffled run from the head, with stray pushes and maybe one late number
    task automatic run_burst();
        logic [SEQ_W-1:0] order[$];
        logic [SEQ_W-1:0] tmp;
        int n;
        int k;
        int late;
        n = ($urandom_range(0, 7) == 0) ? WIN : $urandom_range(1, 8);
        order = {};
        for (int j = 0; j < n; j++) order.push_back(burst_base + SEQ_W'(j));
        for (int j = n - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        late = (n > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
        foreach (order[j]) begin
            if (j != late) push_number(order[j]);
            // noise: stale, far ahead, repeated or anywhere
            case ($urandom_range(0, 15))
                0: push_number(burst_base - 1 - SEQ_W'($urandom_range(0, 40)));
                1: push_number(burst_base + SEQ_W'(WIN + $urandom_range(0, 40)));
                2: push_number(order[j]);
                3: push_number($urandom());
                default: ;
            endcase
        end
        request_release();
        if (late >= 0) begin
            push_number(order[late]);
            request_release();
        end
        if ($urandom_range(0, 5) == 0) request_release();
        burst_base += SEQ_W'(n);
    endtask

    task automatic run_phase(input int phase);
        case ($urandom_range(0, 5))
            0: write_register(CFG_START, '0);
            1: write_register(CFG_START, 32'hFFFF_FFFF - 32'($urandom_range(0, 48)));
            2: write_register(CFG_START, $urandom());
            3: write_register(CFG_WATCHDOG, $urandom());
            4: write_register(($urandom_range(0, 1) != 0) ? CFG_UNMAPPED_A : CFG_UNMAPPED_B,
                              $urandom());
            default: wait_drained();
        endcase
        burst_base = head_seq;
        source_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        sink_idle_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        // long hold at the sink while the source keeps offering
        if (phase == HOLD_PHASE) begin
            hold_requests++;
            source_idle_max = 0;
        end
        repeat ($urandom_range(2, 4)) run_burst();
    endtask

    // Stimulus
    initial begin : stimulus
        int phase;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_op = OP_PUSH;
        s_seq_in = '0;
        s_watchdog_alive = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_index = CFG_START;
        cfg_wr_data = '0;
        row_typed = 1'b0;
        row_kind = KIND_PUSH;
        row_status = STATUS_STORED;
        row_gated = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].what == ROW_WRITE)
                write_register(directed_rows[i].index, directed_rows[i].value);
            else
                send_beat(directed_rows[i].op, directed_rows[i].value, directed_rows[i].alive,
                          directed_rows[i].typed, directed_rows[i].kind,
                          directed_rows[i].status, directed_rows[i].gated);
        end

        // random bursts
        beats_sent = 0;
        phase = 0;
        while (beats_sent < RANDOM_ITEMS) begin
            run_phase(phase);
            phase++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (error_count == 0)
            $display("tb_sequence_reorder_buffer_core: done, clean");
        else
            $display("tb_sequence_reorder_buffer_core: done, errors");
        $finish;
    end

endmodule

@@ sequence_reorder_buffer_core.f @@
sv/srb_pkg.sv
sv/srb_ram.sv
sv/srb_window.sv
sv/sequence_reorder_buffer_core.sv
sv/srb_checker.sv
tb/sv/tb_sequence_reorder_buffer_core.sv
